### rtl/depth_to_flow_projective_warp_assert.svh
// Assertion helpers, clocked on clk and held off during arst_n.
`ifndef DEPTH_TO_FLOW_PROJECTIVE_WARP_ASSERT_SVH
`define DEPTH_TO_FLOW_PROJECTIVE_WARP_ASSERT_SVH

// same-cycle implication
`define DTF_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define DTF_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/dtfpw_pkg.sv
package dtfpw_pkg;

	localparam int COORD_BITS = 12;
	localparam int PORT_CW    = 12;
	localparam int DEPTH_W    = 32;
	localparam int HW         = 32;
	localparam int PW         = DEPTH_W + COORD_BITS;
	localparam int PSPLIT     = PW / 2;
	localparam int PPW        = HW + PSPLIT + 1;
	localparam int PRODW      = HW + PW + 1;
	localparam int QW         = PRODW + 2;
	localparam int QB         = 34;
	localparam int NW         = QW + QB + 2;
	localparam int FRAC       = 16;
	localparam int ESHIFT     = 24;

	localparam logic [3:0] REG_H_PAIR_0 = 4'd0;
	localparam logic [3:0] REG_H_PAIR_1 = 4'd1;
	localparam logic [3:0] REG_H_PAIR_2 = 4'd2;
	localparam logic [3:0] REG_H_PAIR_3 = 4'd3;
	localparam logic [3:0] REG_H_LAST   = 4'd4;
	localparam logic [3:0] REG_SHIFT_X  = 4'd5;
	localparam logic [3:0] REG_SHIFT_Y  = 4'd6;
	localparam logic [3:0] REG_SHIFT_W  = 4'd7;

	localparam logic [31:0] H_ONE = 32'h0010_0000;

	typedef struct packed {
		logic [8:0][HW-1:0] h;
		logic [2:0][31:0]   e;
	} cfg_t;

	typedef struct packed {
		logic [NW-1:0]         num;
		logic [NW-1:0]         den;
		logic                  neg;
		logic                  zero;
		logic [COORD_BITS-1:0] pos;
	} ratio_t;

endpackage

### rtl/dtfpw_mac.sv
// Projection q = H*(d*col, d*row, d) + e, then operand setup for the dividers.
module dtfpw_mac (
	input  logic                              clk,
	input  logic                              ce,
	input  logic [dtfpw_pkg::COORD_BITS-1:0]  col,
	input  logic [dtfpw_pkg::COORD_BITS-1:0]  row,
	input  logic [dtfpw_pkg::DEPTH_W-1:0]     depth,
	input  dtfpw_pkg::cfg_t                   cfg,
	output dtfpw_pkg::ratio_t                 rx,
	output dtfpw_pkg::ratio_t                 ry
);
	localparam int CB = dtfpw_pkg::COORD_BITS;
	localparam int PW = dtfpw_pkg::PW;
	localparam int PS = dtfpw_pkg::PSPLIT;
	localparam int PPW = dtfpw_pkg::PPW;
	localparam int QW = dtfpw_pkg::QW;
	localparam int NW = dtfpw_pkg::NW;

	logic [CB-1:0]                c_s1, r_s1, c_s2, r_s2, c_s3, r_s3;
	logic [2:0][PW-1:0]           p_s1;
	logic signed [PPW-1:0]        plo_s2 [9];
	logic signed [PPW-1:0]        phi_s2 [9];
	logic signed [QW-1:0]         e_s2 [3];
	logic signed [QW-1:0]         q_s3 [3];
	logic [QW-1:0]                mag [3];
	dtfpw_pkg::ratio_t            rx_s4, ry_s4;

	// stage 1: scale the pixel position by depth
	always_ff @(posedge clk) begin
		if (ce) begin
			c_s1    <= col;
			r_s1    <= row;
			p_s1[0] <= PW'(depth) * PW'(col);
			p_s1[1] <= PW'(depth) * PW'(row);
			p_s1[2] <= PW'(depth);
		end
	end

	// stage 2: nine matrix products, each as a low and a high partial product
	always_ff @(posedge clk) begin
		if (ce) begin
			c_s2 <= c_s1;
			r_s2 <= r_s1;
			for (int k = 0; k < 9; k++) begin
				plo_s2[k] <= $signed(cfg.h[k]) * $signed({1'b0, p_s1[k % 3][PS-1:0]});
				phi_s2[k] <= $signed(cfg.h[k]) * $signed({1'b0, p_s1[k % 3][PW-1:PS]});
			end
			for (int k = 0; k < 3; k++) begin
				e_s2[k] <= $signed({{(QW - 32 - dtfpw_pkg::ESHIFT){cfg.e[k][31]}},
					cfg.e[k], {dtfpw_pkg::ESHIFT{1'b0}}});
			end
		end
	end

	// stage 3: row sums of the aligned partial products
	always_ff @(posedge clk) begin
		if (ce) begin
			c_s3 <= c_s2;
			r_s3 <= r_s2;
			for (int k = 0; k < 3; k++) begin
				q_s3[k] <= QW'(plo_s2[3*k]) + (QW'(phi_s2[3*k]) <<< PS)
					+ QW'(plo_s2[3*k+1]) + (QW'(phi_s2[3*k+1]) <<< PS)
					+ QW'(plo_s2[3*k+2]) + (QW'(phi_s2[3*k+2]) <<< PS)
					+ e_s2[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag[k] = q_s3[k][QW-1] ? QW'(-q_s3[k]) : QW'(q_s3[k]);
		end
	end

	// stage 4: magnitudes, rounding offset and signs
	always_ff @(posedge clk) begin
		if (ce) begin
			rx_s4.num  <= NW'({mag[0], 17'b0}) + NW'(mag[2]);
			ry_s4.num  <= NW'({mag[1], 17'b0}) + NW'(mag[2]);
			rx_s4.den  <= NW'({mag[2], 1'b0});
			ry_s4.den  <= NW'({mag[2], 1'b0});
			rx_s4.neg  <= q_s3[0][QW-1] ^ q_s3[2][QW-1];
			ry_s4.neg  <= q_s3[1][QW-1] ^ q_s3[2][QW-1];
			rx_s4.zero <= (q_s3[2] == '0);
			ry_s4.zero <= (q_s3[2] == '0);
			rx_s4.pos  <= c_s3;
			ry_s4.pos  <= r_s3;
		end
	end

	assign rx = rx_s4;
	assign ry = ry_s4;
endmodule

### rtl/dtfpw_div.sv
// Pipelined restoring divider, one quotient bit per stage, then offset and clamp.
module dtfpw_div (
	input  logic              clk,
	input  logic              ce,
	input  dtfpw_pkg::ratio_t din,
	output logic [31:0]       flow,
	output logic              zero
);
	localparam int QB = dtfpw_pkg::QB;
	localparam int NW = dtfpw_pkg::NW;
	localparam int CB = dtfpw_pkg::COORD_BITS;
	localparam int RW = QB + 2;

	logic [NW-1:0] rem_s [QB+1];
	logic [NW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          neg_s [QB+1];
	logic          zero_s [QB+1];
	logic          ovf_s [QB+1];
	logic [CB-1:0] pos_s [QB+1];

	logic signed [RW-1:0] sq, res;
	logic [31:0]          flow_q;
	logic                 zero_q;

	// entry: flag quotients too large for the kept bits
	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0]  <= din.num;
			den_s[0]  <= din.den;
			quo_s[0]  <= '0;
			neg_s[0]  <= din.neg;
			zero_s[0] <= din.zero;
			pos_s[0]  <= din.pos;
			ovf_s[0]  <= din.num >= (din.den << QB);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [NW-1:0] trial;
		assign trial = den_s[k] << (QB - 1 - k);
		always_ff @(posedge clk) begin
			if (ce) begin
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					quo_s[k+1] <= {quo_s[k][QB-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= {quo_s[k][QB-2:0], 1'b0};
				end
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				pos_s[k+1]  <= pos_s[k];
			end
		end
	end

	always_comb begin
		sq  = neg_s[QB] ? -$signed(RW'(quo_s[QB])) : $signed(RW'(quo_s[QB]));
		res = sq - $signed(RW'({pos_s[QB], {dtfpw_pkg::FRAC{1'b0}}}));
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_q <= zero_s[QB];
			if (zero_s[QB]) begin
				flow_q <= '0;
			end else if (ovf_s[QB]) begin
				flow_q <= neg_s[QB] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else if (res < -$signed(RW'(33'h0_8000_0000))) begin
				flow_q <= 32'h8000_0000;
			end else if (res > $signed(RW'(32'h7FFF_FFFF))) begin
				flow_q <= 32'h7FFF_FFFF;
			end else begin
				flow_q <= res[31:0];
			end
		end
	end

	assign flow = flow_q;
	assign zero = zero_q;
endmodule

### rtl/depth_to_flow_projective_warp.sv
// Channel   | Dir | Fields (tdata / tuser, lowest bit up)
// s_axis    | in  | tdata: col[11:0], row[23:12], depth_sample[55:24]
// m_axis    | out | tdata: flow_x[31:0], flow_y[63:32]; tuser: flow_valid
// cfg write | in  | cfg_we, cfg_index (register place), cfg_data (64 bit)
//
// One transaction per cycle in each direction while the output is not stalled;
// the path holds four projection stages, one entry stage plus one stage per
// quotient bit (34) in each divider, and the output register.
// Reset clears the valid chain and loads the registers (H = identity corner).
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
module depth_to_flow_projective_warp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // col, row, depth_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // flow_x, flow_y
	output logic        m_tuser,   // flow_valid
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int CB  = dtfpw_pkg::COORD_BITS;
	localparam int CW  = dtfpw_pkg::PORT_CW;
	localparam int LAT = 4 + dtfpw_pkg::QB + 2;

	logic [3:0][63:0]     hpair_q;
	logic [3:0][31:0]     word_q;   // h_last, shift_x, shift_y, shift_w
	dtfpw_pkg::cfg_t      cfg;
	dtfpw_pkg::ratio_t    rx, ry;
	logic [LAT-1:0]       vld_q;
	logic                 ce;
	logic [31:0]          flow_x, flow_y;
	logic                 zero_x, zero_y;

	// configuration registers; writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpair_q <= '0;
			word_q  <= {32'd0, 32'd0, 32'd0, dtfpw_pkg::H_ONE};
		end else if (cfg_we) begin
			case (cfg_index)
				dtfpw_pkg::REG_H_PAIR_0: hpair_q[0] <= cfg_data;
				dtfpw_pkg::REG_H_PAIR_1: hpair_q[1] <= cfg_data;
				dtfpw_pkg::REG_H_PAIR_2: hpair_q[2] <= cfg_data;
				dtfpw_pkg::REG_H_PAIR_3: hpair_q[3] <= cfg_data;
				dtfpw_pkg::REG_H_LAST:   word_q[0]  <= cfg_data[31:0];
				dtfpw_pkg::REG_SHIFT_X:  word_q[1]  <= cfg_data[31:0];
				dtfpw_pkg::REG_SHIFT_Y:  word_q[2]  <= cfg_data[31:0];
				dtfpw_pkg::REG_SHIFT_W:  word_q[3]  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// unpack H in row-major order, two entries per pair register
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cfg.h[2*k]   = hpair_q[k][31:0];
			cfg.h[2*k+1] = hpair_q[k][63:32];
		end
		cfg.h[8] = word_q[0];
		cfg.e[0] = word_q[1];
		cfg.e[1] = word_q[2];
		cfg.e[2] = word_q[3];
	end

	// advance everything when the output slot is empty or being taken
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	dtfpw_mac u_mac (
		.clk   (clk),
		.ce    (ce),
		.col   (s_tdata[CB-1:0]),
		.row   (s_tdata[CW+CB-1:CW]),
		.depth (s_tdata[55:24]),
		.cfg   (cfg),
		.rx    (rx),
		.ry    (ry)
	);

	dtfpw_div u_div_x (
		.clk  (clk),
		.ce   (ce),
		.din  (rx),
		.flow (flow_x),
		.zero (zero_x)
	);

	dtfpw_div u_div_y (
		.clk  (clk),
		.ce   (ce),
		.din  (ry),
		.flow (flow_y),
		.zero (zero_y)
	);

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {flow_y, flow_x};
	assign m_tuser  = !zero_x;

	`include "depth_to_flow_projective_warp_assert.svh"

	`DTF_AST_NOW(a_ready_follows_out, 1'b1, s_tready == (!m_tvalid || m_tready))
	`DTF_AST_NOW(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == 64'd0)
	`DTF_AST_NOW(a_lanes_agree, m_tvalid, zero_x == zero_y)
	`DTF_AST_NEXT(a_accept_enters, s_tvalid && s_tready, vld_q[0])
endmodule
